FILE: src/torque_command_frame_parser_assert.svh
// Assertion macros for the torque command frame parser.
// Files that use them must have clk and rst_n in scope.
`ifndef TORQUE_COMMAND_FRAME_PARSER_ASSERT_SVH
`define TORQUE_COMMAND_FRAME_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tcfp_pkg.sv
// Shared types and constants for the torque command frame parser.
// No dependencies; used by the channel interfaces and the top level.
package tcfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int TORQUE_W    = 14;
    localparam int FRAME_LEN   = 15;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
    localparam int BUF_LEN_DEF = 64;

    localparam logic [TORQUE_W-1:0] TORQUE_LIMIT_RST = 14'd1500;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_L     = 8'h4C;
    localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_M     = 8'h4D;
    localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TERM  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_WRONG_LEN = 2'd3
    } status_t;

endpackage

FILE: src/tcfp_rx_if.sv
// Receive byte channel of the torque command frame parser.
// Depends on tcfp_pkg for the byte width.
interface tcfp_rx_if;
    logic                         valid;
    logic                         ready;
    logic [tcfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/tcfp_cfg_if.sv
// Configuration write channel carrying the torque limit.
// Depends on tcfp_pkg for the torque width.
interface tcfp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcfp_pkg::TORQUE_W-1:0] torque_limit;

    modport source (output valid, output torque_limit, input ready);
    modport sink   (input valid, input torque_limit, output ready);
endinterface

FILE: src/tcfp_res_if.sv
// Result channel of the torque command frame parser.
// Depends on tcfp_pkg for widths and the status type.
interface tcfp_res_if;
    logic                          valid;
    logic                          ready;
    tcfp_pkg::status_t             status;
    logic [tcfp_pkg::TORQUE_W-1:0] torque_left;
    logic [tcfp_pkg::TORQUE_W-1:0] torque_right;
    logic                          left_updated;
    logic                          right_updated;
    logic [tcfp_pkg::BYTE_W-1:0]   motion_mode;
    logic [tcfp_pkg::BYTE_W-1:0]   asym_side;
    logic [tcfp_pkg::BYTE_W-1:0]   previous_mode;
    logic                          mode_updated;

    modport source (
        output valid, output status, output torque_left, output torque_right,
        output left_updated, output right_updated, output motion_mode,
        output asym_side, output previous_mode, output mode_updated,
        input ready
    );
    modport sink (
        input valid, input status, input torque_left, input torque_right,
        input left_updated, input right_updated, input motion_mode,
        input asym_side, input previous_mode, input mode_updated,
        output ready
    );
endinterface

FILE: src/torque_command_frame_parser.sv
// Top level of the torque command frame parser: byte framing, tag checks and held values.
// Depends on tcfp_pkg, the tcfp_*_if interfaces and torque_command_frame_parser_assert.svh.
//
//   Channel  Dir  Payload                          Transaction meaning
//   rx       in   rx_byte                          one received serial byte
//   cfg      in   torque_limit                     new torque clamp value
//   result   out  status, torques, mode, flags     one finished or failed frame
//
// One byte is taken every cycle while rx ready is high. A byte is parsed while it sits in the input register, so
// a result is loaded into the result register from the input register stage.
// The parse stage advances only when the result register is empty or being drained, so a
// stalled result holds the input register, and the rx ready drops once that is full too.
// Reset clears the frame count, the CR flag, the held values and the limit (to 1500).
// The frame store needs no clearing, since a frame is checked only after all its bytes
// were written.
module torque_command_frame_parser #(
    parameter int BUF_LEN = tcfp_pkg::BUF_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    tcfp_rx_if.sink           rx,
    tcfp_cfg_if.sink          cfg,
    tcfp_res_if.source        result
);

    `include "torque_command_frame_parser_assert.svh"

    // The count must be able to hold BUF_LEN itself.
    localparam int CNT_W = $clog2(BUF_LEN + 1);

    localparam int BW = tcfp_pkg::BYTE_W;
    localparam int TW = tcfp_pkg::TORQUE_W;

    // Four ASCII digits to hundredths, clamped to 0..limit. A non-digit byte still counts
    // as byte minus 48, so the sum is signed and can leave the range on either side.
    function automatic logic [TW-1:0] torque_from(
        input logic [BW-1:0] b3,
        input logic [BW-1:0] b2,
        input logic [BW-1:0] b1,
        input logic [BW-1:0] b0,
        input logic [TW-1:0] lim
    );
        logic signed [8:0]  g3;
        logic signed [8:0]  g2;
        logic signed [8:0]  g1;
        logic signed [8:0]  g0;
        logic signed [18:0] v;
        g3 = $signed({1'b0, b3}) - $signed({1'b0, tcfp_pkg::DIGIT_BASE});
        g2 = $signed({1'b0, b2}) - $signed({1'b0, tcfp_pkg::DIGIT_BASE});
        g1 = $signed({1'b0, b1}) - $signed({1'b0, tcfp_pkg::DIGIT_BASE});
        g0 = $signed({1'b0, b0}) - $signed({1'b0, tcfp_pkg::DIGIT_BASE});
        v  = 19'(g3) * 19'sd1000 + 19'(g2) * 19'sd100 + 19'(g1) * 19'sd10 + 19'(g0);
        if (v >= $signed({5'b0, lim})) begin
            return lim;
        end
        else if (v < 19'sd0) begin
            return '0;
        end
        else begin
            return v[TW-1:0];
        end
    endfunction

    // Configuration.
    logic [TW-1:0] torque_limit_reg;

    // Input register.
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;

    // Parser state.
    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic             after_cr_reg, after_cr_next;
    logic [BW-1:0]    frame_bytes_reg [tcfp_pkg::FRAME_LEN];
    logic [TW-1:0]    held_left_reg, held_left_next;
    logic [TW-1:0]    held_right_reg, held_right_next;
    logic [BW-1:0]    held_mode_reg, held_mode_next;
    logic [BW-1:0]    held_prev_reg, held_prev_next;
    logic [BW-1:0]    held_side_reg, held_side_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    tcfp_pkg::status_t status_reg, status_next;
    logic              left_upd_reg, left_upd_next;
    logic              right_upd_reg, right_upd_next;
    logic              mode_upd_reg, mode_upd_next;

    logic                              out_free;
    logic                              process;
    logic                              has_result;
    logic                              store_en;
    logic [tcfp_pkg::FRAME_IDX_W-1:0]  store_idx;

    assign out_free  = !out_valid_reg || result.ready;
    assign process   = in_valid_reg && out_free;
    assign rx.ready  = !in_valid_reg || process;
    assign cfg.ready = 1'b1;
    assign store_idx = char_count_reg[tcfp_pkg::FRAME_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            torque_limit_reg <= tcfp_pkg::TORQUE_LIMIT_RST;
        end
        else if (cfg.valid) begin
            torque_limit_reg <= cfg.torque_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready) begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (rx.valid && rx.ready) begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Parse stage: one byte of framing, and on CR LF of a full frame the tag checks.
    always_comb begin
        char_count_next = char_count_reg;
        after_cr_next   = after_cr_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        held_mode_next  = held_mode_reg;
        held_prev_next  = held_prev_reg;
        held_side_next  = held_side_reg;
        has_result      = 1'b0;
        store_en        = 1'b0;
        status_next     = tcfp_pkg::ST_OK;
        left_upd_next   = 1'b0;
        right_upd_next  = 1'b0;
        mode_upd_next   = 1'b0;

        if (process) begin
            if (after_cr_reg) begin
                // Whatever follows a CR closes the frame.
                after_cr_next   = 1'b0;
                char_count_next = '0;
                has_result      = 1'b1;
                if (in_byte_reg != tcfp_pkg::CHAR_LF) begin
                    status_next = tcfp_pkg::ST_BAD_TERM;
                end
                else if (char_count_reg != CNT_W'(tcfp_pkg::FRAME_LEN)) begin
                    status_next = tcfp_pkg::ST_WRONG_LEN;
                end
                else begin
                    if (frame_bytes_reg[0] == tcfp_pkg::CHAR_T &&
                        frame_bytes_reg[1] == tcfp_pkg::CHAR_L) begin
                        held_left_next = torque_from(frame_bytes_reg[2], frame_bytes_reg[3],
                                                     frame_bytes_reg[4], frame_bytes_reg[5],
                                                     torque_limit_reg);
                        left_upd_next  = 1'b1;
                    end
                    if (frame_bytes_reg[6] == tcfp_pkg::CHAR_T &&
                        frame_bytes_reg[7] == tcfp_pkg::CHAR_R) begin
                        held_right_next = torque_from(frame_bytes_reg[8], frame_bytes_reg[9],
                                                      frame_bytes_reg[10], frame_bytes_reg[11],
                                                      torque_limit_reg);
                        right_upd_next  = 1'b1;
                    end
                    if (frame_bytes_reg[12] == tcfp_pkg::CHAR_M) begin
                        held_prev_next = held_mode_reg;
                        held_mode_next = frame_bytes_reg[13] - tcfp_pkg::DIGIT_BASE;
                        held_side_next = frame_bytes_reg[14] - tcfp_pkg::DIGIT_BASE;
                        mode_upd_next  = 1'b1;
                    end
                end
            end
            else if (in_byte_reg == tcfp_pkg::CHAR_CR) begin
                after_cr_next = 1'b1;
            end
            else if (char_count_reg < CNT_W'(BUF_LEN)) begin
                // Only the first frame-length bytes are kept; the rest are only counted.
                store_en        = char_count_reg < CNT_W'(tcfp_pkg::FRAME_LEN);
                char_count_next = char_count_reg + CNT_W'(1);
            end
            else begin
                char_count_next = '0;
                has_result      = 1'b1;
                status_next     = tcfp_pkg::ST_OVERFLOW;
            end
        end

        if (process && has_result) begin
            out_valid_next = 1'b1;
        end
        else if (result.ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            char_count_reg <= '0;
            after_cr_reg   <= 1'b0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
            held_mode_reg  <= '0;
            held_prev_reg  <= '0;
            held_side_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            char_count_reg <= char_count_next;
            after_cr_reg   <= after_cr_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            held_mode_reg  <= held_mode_next;
            held_prev_reg  <= held_prev_next;
            held_side_reg  <= held_side_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (store_en) begin
            frame_bytes_reg[store_idx] <= in_byte_reg;
        end
    end

    // Result flags and status load together with the result valid.
    always_ff @(posedge clk) begin
        if (process && has_result) begin
            status_reg    <= status_next;
            left_upd_reg  <= left_upd_next;
            right_upd_reg <= right_upd_next;
            mode_upd_reg  <= mode_upd_next;
        end
    end

    // The held values only change when a result is produced, so they can drive the
    // result fields directly.
    assign result.valid         = out_valid_reg;
    assign result.status        = status_reg;
    assign result.torque_left   = held_left_reg;
    assign result.torque_right  = held_right_reg;
    assign result.left_updated  = left_upd_reg;
    assign result.right_updated = right_upd_reg;
    assign result.motion_mode   = held_mode_reg;
    assign result.asym_side     = held_side_reg;
    assign result.previous_mode = held_prev_reg;
    assign result.mode_updated  = mode_upd_reg;

    // An error result never reports an update.
    `TCFP_ASSERT_SAME(a_err_no_update, out_valid_reg && status_reg != tcfp_pkg::ST_OK, !left_upd_reg && !right_upd_reg && !mode_upd_reg, "update flag set on error result")
    // The byte count never runs past the buffer length.
    `TCFP_ASSERT_SAME(a_count_bound, 1'b1, char_count_reg <= CNT_W'(BUF_LEN), "char count above buffer length")
    // The byte after a CR always closes the frame and starts a new one.
    `TCFP_ASSERT_NEXT(a_cr_restart, process && after_cr_reg, char_count_reg == '0 && !after_cr_reg && out_valid_reg, "frame not closed after CR")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for torque_command_frame_parser: byte stream in, frame results out.
// Depends on tcfp_pkg, the tcfp_rx_if, tcfp_cfg_if and tcfp_res_if interfaces, and the RTL.
// A behavioral frame parser predicts results, typed rows aside; a directed table runs first, then random.
`timescale 1ns / 1ps

module tb_top;

    // Buffer depth of the instance below; it keeps the block's default.
    localparam int BUF_LEN         = tcfp_pkg::BUF_LEN_DEF;
    // Table strings cannot carry a zero byte, so DEL in a row stands for 0x00.
    localparam logic [7:0] ZERO_STAND_IN = 8'h7F;
    localparam int RAND_ITEMS      = 300;
    localparam int RAND_PHASES     = 5;
    localparam int HOLD_OFF_CYCLES = 300;
    // A byte passes through the input register on its way to the result register; allow some slack.
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int CYCLE_LIMIT     = 400000;

    // One result transaction, fields in port order.
    typedef struct {
        tcfp_pkg::status_t             status;
        logic [tcfp_pkg::TORQUE_W-1:0] torque_left;
        logic [tcfp_pkg::TORQUE_W-1:0] torque_right;
        logic                          left_updated;
        logic                          right_updated;
        logic [7:0]                    motion_mode;
        logic [7:0]                    asym_side;
        logic [7:0]                    previous_mode;
        logic                          mode_updated;
    } frame_result_t;

    // One row of the directed table. A row with a typed result has it checked on the
    // result caused by its last byte; every other result comes from the predictor.
    typedef struct {
        int            new_limit;   // negative keeps the current limit
        string         text;
        bit            typed;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NO_RESULT =
        '{tcfp_pkg::ST_OK, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0};

    logic clk;
    logic rst_n;

    tcfp_rx_if  rx_ch ();
    tcfp_cfg_if cfg_ch ();
    tcfp_res_if res_ch ();

    torque_command_frame_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // Predictor state: a copy of the parser's framing state, its held values and the limit.
    int                            byte_count  = 0;
    bit                            saw_cr      = 1'b0;
    logic [7:0]                    frame_store [tcfp_pkg::FRAME_LEN];
    logic [tcfp_pkg::TORQUE_W-1:0] held_left   = '0;
    logic [tcfp_pkg::TORQUE_W-1:0] held_right  = '0;
    logic [7:0]                    held_mode   = '0;
    logic [7:0]                    held_prev   = '0;
    logic [7:0]                    held_side   = '0;
    logic [tcfp_pkg::TORQUE_W-1:0] torque_lim  = tcfp_pkg::TORQUE_LIMIT_RST;

    frame_result_t expected_results [$];
    stim_row_t     dir_rows [$];
    logic [7:0]    burst [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit src_calm       = 1'b0;
    bit sink_calm      = 1'b0;
    bit hold_off_req   = 1'b0;

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit chance(input int percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_non_cr();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == tcfp_pkg::CHAR_CR);
        return b;
    endfunction

    // Four-digit torque starting at the given store index, in hundredths. Non-digit bytes
    // still count as byte minus 48, so the signed sum is clamped to 0 .. limit.
    function automatic logic [tcfp_pkg::TORQUE_W-1:0] clamp_torque(input int base);
        int sum;
        sum = (int'(frame_store[base])     - 48) * 1000 +
              (int'(frame_store[base + 1]) - 48) * 100  +
              (int'(frame_store[base + 2]) - 48) * 10   +
              (int'(frame_store[base + 3]) - 48);
        if (sum >= int'(torque_lim))
            return torque_lim;
        if (sum < 0)
            return '0;
        return sum[tcfp_pkg::TORQUE_W-1:0];
    endfunction

    // Advance the predicted parser by one accepted byte. A result is produced by the byte
    // after a CR (good frame, bad terminator or wrong length) and by a byte that would
    // overflow the buffer. Held values update only on a good frame with matching tags.
    task automatic parse_byte(input logic [7:0] b, output bit produced,
                              output frame_result_t r);
        tcfp_pkg::status_t st;
        logic              lu;
        logic              ru;
        logic              mu;
        st       = tcfp_pkg::ST_OK;
        lu       = 1'b0;
        ru       = 1'b0;
        mu       = 1'b0;
        produced = 1'b0;
        if (saw_cr)
        begin
            saw_cr   = 1'b0;
            produced = 1'b1;
            if (b != tcfp_pkg::CHAR_LF)
                st = tcfp_pkg::ST_BAD_TERM;          // the byte after the CR is dropped
            else if (byte_count != tcfp_pkg::FRAME_LEN)
                st = tcfp_pkg::ST_WRONG_LEN;
            else
            begin
                if (frame_store[0] == tcfp_pkg::CHAR_T && frame_store[1] == tcfp_pkg::CHAR_L)
                begin
                    held_left = clamp_torque(2);
                    lu        = 1'b1;
                end
                if (frame_store[6] == tcfp_pkg::CHAR_T && frame_store[7] == tcfp_pkg::CHAR_R)
                begin
                    held_right = clamp_torque(8);
                    ru         = 1'b1;
                end
                if (frame_store[12] == tcfp_pkg::CHAR_M)
                begin
                    held_prev = held_mode;
                    held_mode = frame_store[13] - tcfp_pkg::DIGIT_BASE;
                    held_side = frame_store[14] - tcfp_pkg::DIGIT_BASE;
                    mu        = 1'b1;
                end
            end
            byte_count = 0;
        end
        else if (b == tcfp_pkg::CHAR_CR)
            saw_cr = 1'b1;
        else if (byte_count < BUF_LEN)
        begin
            if (byte_count < tcfp_pkg::FRAME_LEN)
                frame_store[byte_count] = b;
            byte_count++;
        end
        else
        begin
            // Buffer already full: this byte is dropped and the frame restarts.
            byte_count = 0;
            st         = tcfp_pkg::ST_OVERFLOW;
            produced   = 1'b1;
        end
        r = '{st, held_left, held_right, lu, ru, held_mode, held_side, held_prev, mu};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compare one result transaction with the oldest pending expectation.
    task automatic check_frame_result();
        frame_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing pending, status", res_ch.status, 0);
            return;
        end
        want = expected_results.pop_front();
        if (res_ch.status !== want.status)
            report_mismatch("status", res_ch.status, want.status);
        if (res_ch.torque_left !== want.torque_left)
            report_mismatch("torque_left", res_ch.torque_left, want.torque_left);
        if (res_ch.torque_right !== want.torque_right)
            report_mismatch("torque_right", res_ch.torque_right, want.torque_right);
        if (res_ch.left_updated !== want.left_updated)
            report_mismatch("left_updated", res_ch.left_updated, want.left_updated);
        if (res_ch.right_updated !== want.right_updated)
            report_mismatch("right_updated", res_ch.right_updated, want.right_updated);
        if (res_ch.motion_mode !== want.motion_mode)
            report_mismatch("motion_mode", res_ch.motion_mode, want.motion_mode);
        if (res_ch.asym_side !== want.asym_side)
            report_mismatch("asym_side", res_ch.asym_side, want.asym_side);
        if (res_ch.previous_mode !== want.previous_mode)
            report_mismatch("previous_mode", res_ch.previous_mode, want.previous_mode);
        if (res_ch.mode_updated !== want.mode_updated)
            report_mismatch("mode_updated", res_ch.mode_updated, want.mode_updated);
    endtask

    // Result monitor. Values are read at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            check_frame_result();
    end

    // Result receiver. It stalls at random, has calm stretches with ready held high, and
    // on request holds ready low for a long stretch so that the block backs up into rx.
    initial
    begin : result_sink
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                sink_calm = ~sink_calm;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!sink_calm && chance(20))
                    stall = pick_gap();
            end
        end
    end

    // Offer one byte after a random gap and wait for its transaction. Valid stays high
    // after the transaction, so back-to-back bytes never lower and raise it in one step.
    // On acceptance the predictor runs; a typed row result replaces its prediction.
    task automatic send_byte(input logic [7:0] b, input bit override,
                             input frame_result_t want);
        int            gap;
        bit            produced;
        frame_result_t pred;
        gap = src_calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        parse_byte(b, produced, pred);
        if (produced)
            expected_results.push_back(override ? want : pred);
    endtask

    // Stop offering bytes and wait for every pending result, then for the bytes that
    // cause no result to clear the pipeline.
    task automatic settle_block();
        int waited;
        waited = 0;
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_results.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the torque limit while the block is idle; the predictor takes it on acceptance.
    task automatic write_limit(input logic [tcfp_pkg::TORQUE_W-1:0] value);
        settle_block();
        @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.torque_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        torque_lim = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Build one random burst of bytes. Most bursts are well-formed frames with random
    // content; the rest are short or long frames, broken terminators, buffer overruns
    // and raw noise.
    task automatic fill_burst();
        int kind;
        int n;
        burst.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            burst.push_back(chance(92) ? tcfp_pkg::CHAR_T : rand_non_cr());
            burst.push_back(chance(92) ? tcfp_pkg::CHAR_L : rand_non_cr());
            repeat (4) burst.push_back(chance(85)
                ? 8'(tcfp_pkg::DIGIT_BASE + $urandom_range(0, 9)) : rand_non_cr());
            burst.push_back(chance(92) ? tcfp_pkg::CHAR_T : rand_non_cr());
            burst.push_back(chance(92) ? tcfp_pkg::CHAR_R : rand_non_cr());
            repeat (4) burst.push_back(chance(85)
                ? 8'(tcfp_pkg::DIGIT_BASE + $urandom_range(0, 9)) : rand_non_cr());
            burst.push_back(chance(92) ? tcfp_pkg::CHAR_M : rand_non_cr());
            repeat (2) burst.push_back(chance(70)
                ? 8'(tcfp_pkg::DIGIT_BASE + $urandom_range(0, 9)) : rand_non_cr());
            burst.push_back(tcfp_pkg::CHAR_CR);
            burst.push_back(tcfp_pkg::CHAR_LF);
        end
        else if (kind < 80)
        begin
            // Random length, mostly wrong, occasionally right up to a full buffer.
            n = chance(15) ? BUF_LEN : $urandom_range(0, 30);
            repeat (n) burst.push_back(rand_non_cr());
            burst.push_back(tcfp_pkg::CHAR_CR);
            burst.push_back(tcfp_pkg::CHAR_LF);
        end
        else if (kind < 88)
        begin
            // CR followed by something other than LF.
            repeat ($urandom_range(0, 20)) burst.push_back(rand_non_cr());
            burst.push_back(tcfp_pkg::CHAR_CR);
            do
                n = $urandom_range(0, 255);
            while (n == tcfp_pkg::CHAR_LF);
            burst.push_back(n[7:0]);
        end
        else if (kind < 93)
        begin
            // One byte more than the buffer holds.
            repeat (BUF_LEN + 1) burst.push_back(rand_non_cr());
        end
        else
        begin
            repeat ($urandom_range(1, 10)) burst.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial
    begin : stimulus
        logic [7:0] b;
        int         sent;
        int         last;
        rst_n               = 1'b0;
        rx_ch.valid         = 1'b0;
        rx_ch.rx_byte       = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.torque_limit = '0;

        // Directed rows. Typed results assume the limit still at its reset value of 1500
        // through the overflow row.
        dir_rows.push_back(stim_row_t'{-1, "TL0500TR0700M12\r\n", 1'b1,
            frame_result_t'{tcfp_pkg::ST_OK, 14'd500, 14'd700, 1'b1, 1'b1, 8'd1, 8'd2,
                            8'd0, 1'b1}});
        // Left torque above the limit clamps to it; all-zero right torque stays zero.
        dir_rows.push_back(stim_row_t'{-1, "TL9999TR0000M00\r\n", 1'b1,
            frame_result_t'{tcfp_pkg::ST_OK, 14'd1500, 14'd0, 1'b1, 1'b1, 8'd0, 8'd0,
                            8'd1, 1'b1}});
        dir_rows.push_back(stim_row_t'{-1, "AB\r\n", 1'b1,
            frame_result_t'{tcfp_pkg::ST_WRONG_LEN, 14'd1500, 14'd0, 1'b0, 1'b0, 8'd0,
                            8'd0, 8'd1, 1'b0}});
        dir_rows.push_back(stim_row_t'{-1, "TL01\rX", 1'b1,
            frame_result_t'{tcfp_pkg::ST_BAD_TERM, 14'd1500, 14'd0, 1'b0, 1'b0, 8'd0,
                            8'd0, 8'd1, 1'b0}});
        dir_rows.push_back(stim_row_t'{-1, "\r\n", 1'b1,
            frame_result_t'{tcfp_pkg::ST_WRONG_LEN, 14'd1500, 14'd0, 1'b0, 1'b0, 8'd0,
                            8'd0, 8'd1, 1'b0}});
        // Sixty-five bytes: the last one overruns the 64-byte buffer.
        dir_rows.push_back(stim_row_t'{-1,
            "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789012", 1'b1,
            frame_result_t'{tcfp_pkg::ST_OVERFLOW, 14'd1500, 14'd0, 1'b0, 1'b0, 8'd0,
                            8'd0, 8'd1, 1'b0}});
        // Non-digit bytes in both torques, byte extremes 0xFF and 0x00 in mode and side.
        dir_rows.push_back(stim_row_t'{-1, "TL~~~~TR////M\377\177\r\n", 1'b0, NO_RESULT});
        // Right length, but no tag matches.
        dir_rows.push_back(stim_row_t'{-1, "TX1234TL5678N12\r\n", 1'b0, NO_RESULT});
        dir_rows.push_back(stim_row_t'{9999, "TL9999TR1234M34\r\n", 1'b0, NO_RESULT});
        dir_rows.push_back(stim_row_t'{0, "TL0000TR0001M56\r\n", 1'b0, NO_RESULT});
        // A second CR right after a CR is the dropped byte of a bad terminator.
        dir_rows.push_back(stim_row_t'{-1, "TL\r\r", 1'b0, NO_RESULT});
        // A bare LF is ordinary data, which makes this frame one byte too long.
        dir_rows.push_back(stim_row_t'{-1, "\nTL0100TR0200M78\r\n", 1'b0, NO_RESULT});
        // Just below and exactly at the limit.
        dir_rows.push_back(stim_row_t'{1500, "TL1499TR1500M:;\r\n", 1'b0, NO_RESULT});
        // A full buffer followed by CR LF is a wrong length, not an overflow.
        dir_rows.push_back(stim_row_t'{-1,
            "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ012345678901\r\n", 1'b0,
            NO_RESULT});

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].new_limit >= 0)
                write_limit(dir_rows[r].new_limit[tcfp_pkg::TORQUE_W-1:0]);
            last = dir_rows[r].text.len() - 1;
            for (int i = 0; i <= last; i++)
            begin
                b = dir_rows[r].text[i];
                if (b == ZERO_STAND_IN)
                    b = 8'h00;
                send_byte(b, dir_rows[r].typed && (i == last), dir_rows[r].want);
            end
        end

        // Random phases, each under its own limit: the top extreme, a random one, zero,
        // then random again. The second phase also runs the long receiver hold-off with
        // the sender offering back to back, so the block fills up and stalls rx.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                write_limit(14'd9999);
            else if (ph == 2)
                write_limit(14'd0);
            else
                write_limit(14'($urandom_range(0, 9999)));
            src_calm = (ph == 1) || (ph == 3);
            if (ph == 1)
            begin
                @(posedge clk);
                hold_off_req = 1'b1;
            end
            sent = 0;
            while (sent < RAND_ITEMS / RAND_PHASES)
            begin
                fill_burst();
                foreach (burst[i])
                    send_byte(burst[i], 1'b0, NO_RESULT);
                sent += burst.size();
            end
        end

        settle_block();
        if (expected_results.size() > 0)
            report_mismatch("results still pending at end", expected_results.size(), 0);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/tcfp_pkg.sv
src/tcfp_rx_if.sv
src/tcfp_cfg_if.sv
src/tcfp_res_if.sv
src/torque_command_frame_parser.sv
verif/tb_top.sv
